// ----- hdl/vector_distance_engine_macros.svh -----
// Assertion macros shared by the vector distance engine.
`ifndef VECTOR_DISTANCE_ENGINE_MACROS_SVH
`define VECTOR_DISTANCE_ENGINE_MACROS_SVH
`ifndef ASSERT_OFF
`define VDE_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("vde assertion failed");
`define VDE_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("vde assertion failed");
`else
`define VDE_ASSERT_IMPLY(label, clk, rst, a, b)
`define VDE_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ----- hdl/vde_pkg.sv -----
// Types and constants of the vector distance engine.
package vde_pkg;

  localparam logic [1:0] METRIC_L1      = 2'd0;
  localparam logic [1:0] METRIC_L2SQ    = 2'd1;
  localparam logic [1:0] METRIC_COSINE  = 2'd2;
  localparam logic [1:0] METRIC_INVALID = 2'd3;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_ZERO_NORM = 2'd1;
  localparam logic [1:0] STATUS_BAD       = 2'd2;
  localparam logic [1:0] STATUS_SAT       = 2'd3;

  localparam logic [47:0] DIST_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] ONE_Q30  = 48'h0000_4000_0000;

  typedef struct packed {
    logic signed [15:0] point_value;
    logic signed [15:0] center_value;
    logic               last_element;
  } in_t;

  typedef struct packed {
    logic [47:0] distance;
    logic [1:0]  status;
  } out_t;

  typedef struct packed {
    logic [1:0]         metric;
    logic [47:0]        diff_sum;
    logic               diff_sat;
    logic signed [40:0] dot_sum;
    logic               cos_sat;
    logic [39:0]        point_norm_sq;
    logic [39:0]        center_norm_sq;
    logic               over_dim;
  } rec_t;

endpackage

// ----- hdl/vector_distance_engine.sv -----
// Vector distance engine: L1, squared L2 or cosine distance of streamed vector pairs.
// Element pairs are taken one per cycle while the two-entry result queue has room, through a
// three-stage accumulate pipeline; a pair marked last closes the vector and pushes its sums.
// L1, squared L2 and error results are registered by the back end from the queued sums; a cosine
// result passes the 32-step bit-serial square roots, the MUL and DIVINIT states, the 52-step
// restoring divide and the FIN state, and skips the divide when the quotient clamps.
// Results come out in vector order.
`include "vector_distance_engine_macros.svh"
module vector_distance_engine #(
  parameter int MAX_DIM      = 128,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  input  logic          in_valid,
  output logic          in_stall,
  input  vde_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output vde_pkg::out_t out_data
);
  logic [1:0] metric;
  logic q_full, q_valid, push, pop;
  vde_pkg::rec_t push_rec, head_rec;

  assign pready   = 1'b1;
  assign prdata   = (paddr == 3'd0) ? 32'(metric) : '0;
  assign in_stall = q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      metric <= vde_pkg::METRIC_L1;
    end else if (psel && penable && pwrite && paddr == 3'd0) begin
      metric <= pwdata[1:0];
    end
  end

  vde_front #(.MAX_DIM(MAX_DIM), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
    .clk(clk), .rst(rst), .metric(metric), .in_valid(in_valid), .in_data(in_data),
    .q_full(q_full), .push(push), .push_rec(push_rec)
  );

  vde_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_rec(push_rec), .pop(pop),
    .full(q_full), .not_empty(q_valid), .head_rec(head_rec)
  );

  vde_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_rec(head_rec), .pop(pop),
    .out_valid(out_valid), .out_data(out_data), .out_stall(out_stall)
  );

  `VDE_ASSERT_IMPLY(a_bad_zero, clk, rst, out_valid && out_data.status == vde_pkg::STATUS_BAD, out_data.distance == '0)
  `VDE_ASSERT_IMPLY(a_sat_max, clk, rst, out_valid && out_data.status == vde_pkg::STATUS_SAT, out_data.distance == vde_pkg::DIST_MAX)
  `VDE_ASSERT_IMPLY(a_cos_range, clk, rst, out_valid && metric == vde_pkg::METRIC_COSINE && out_data.status == vde_pkg::STATUS_OK, out_data.distance <= 48'h0000_8000_0000)
endmodule

// ----- hdl/vde_front.sv -----
// Front end: takes element pairs and keeps the running sums of one vector.
module vde_front #(
  parameter int MAX_DIM      = 128,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    metric,
  input  logic          in_valid,
  input  vde_pkg::in_t  in_data,
  input  logic          q_full,
  output logic          push,
  output vde_pkg::rec_t push_rec
);
  localparam int SW = SAMPLE_WIDTH;
  localparam int RW = (SW > 16) ? SW : 16;
  localparam int PW = 2 * SW;
  localparam int TW = 2 * SW + 1;
  localparam int AW = 51;
  localparam logic signed [AW-1:0] DOT_MAX = AW'((64'd1 << 40) - 64'd1);
  localparam logic signed [AW-1:0] DOT_MIN = -DOT_MAX - AW'(1);
  localparam logic [AW-1:0] NORM_MAX = AW'((64'd1 << 40) - 64'd1);
  localparam logic [AW-1:0] DIFF_MAX = AW'((64'd1 << 48) - 64'd1);

  logic en;
  logic [RW-1:0] p_raw, c_raw;
  logic signed [SW-1:0] p_in, c_in;

  logic a_valid, a_last;
  logic [1:0] a_metric;
  logic signed [SW-1:0] a_p, a_c;
  logic signed [SW:0] a_d;
  logic [SW:0] a_ad;

  logic b_valid, b_last;
  logic [1:0] b_metric;
  logic [TW-1:0] b_term;
  logic signed [PW-1:0] b_dot;
  logic signed [PW-1:0] b_pp, b_cc;

  logic [47:0] diff_sum;
  logic signed [40:0] dot_sum;
  logic [39:0] point_norm_sq, center_norm_sq;
  logic [12:0] element_count;
  logic diff_sat, cos_sat;

  logic [AW-1:0] diff_s, pn_s, cn_s;
  logic signed [AW-1:0] dot_s;
  logic [47:0] diff_next;
  logic signed [40:0] dot_next;
  logic [39:0] pn_next, cn_next;
  logic [12:0] count_next;
  logic diff_sat_next, cos_sat_next;

  assign en    = !q_full;
  assign p_raw = RW'(unsigned'(in_data.point_value));
  assign c_raw = RW'(unsigned'(in_data.center_value));
  assign p_in  = signed'(p_raw[SW-1:0]);
  assign c_in  = signed'(c_raw[SW-1:0]);
  assign a_ad  = a_d[SW] ? unsigned'(-a_d) : unsigned'(a_d);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
    end
    if (en) begin
      a_p      <= p_in;
      a_c      <= c_in;
      a_d      <= (SW+1)'(p_in) - (SW+1)'(c_in);
      a_last   <= in_data.last_element;
      a_metric <= metric;
      b_last   <= a_last;
      b_metric <= a_metric;
      b_term   <= (a_metric == vde_pkg::METRIC_L1) ? TW'(a_ad) : TW'(a_ad) * TW'(a_ad);
      b_dot    <= PW'(a_p) * PW'(a_c);
      b_pp     <= PW'(a_p) * PW'(a_p);
      b_cc     <= PW'(a_c) * PW'(a_c);
    end
  end

  always_comb begin
    diff_s = AW'(diff_sum) + AW'(b_term);
    dot_s  = AW'(dot_sum) + AW'(b_dot);
    pn_s   = AW'(point_norm_sq) + AW'(unsigned'(b_pp));
    cn_s   = AW'(center_norm_sq) + AW'(unsigned'(b_cc));
    diff_next     = diff_sum;
    diff_sat_next = diff_sat;
    cos_sat_next  = cos_sat;
    if (b_metric == vde_pkg::METRIC_L1 || b_metric == vde_pkg::METRIC_L2SQ) begin
      if (diff_s > DIFF_MAX) begin
        diff_next     = 48'(DIFF_MAX);
        diff_sat_next = 1'b1;
      end else begin
        diff_next = diff_s[47:0];
      end
    end
    if (dot_s > DOT_MAX) begin
      dot_next     = 41'(DOT_MAX);
      cos_sat_next = 1'b1;
    end else if (dot_s < DOT_MIN) begin
      dot_next     = 41'(DOT_MIN);
      cos_sat_next = 1'b1;
    end else begin
      dot_next = dot_s[40:0];
    end
    if (pn_s > NORM_MAX) begin
      pn_next      = 40'(NORM_MAX);
      cos_sat_next = 1'b1;
    end else begin
      pn_next = pn_s[39:0];
    end
    if (cn_s > NORM_MAX) begin
      cn_next      = 40'(NORM_MAX);
      cos_sat_next = 1'b1;
    end else begin
      cn_next = cn_s[39:0];
    end
    count_next = (element_count == 13'h1FFF) ? element_count : element_count + 13'd1;
  end

  assign push = en && b_valid && b_last;

  always_comb begin
    push_rec.metric         = b_metric;
    push_rec.diff_sum       = diff_next;
    push_rec.diff_sat       = diff_sat_next;
    push_rec.dot_sum        = dot_next;
    push_rec.cos_sat        = cos_sat_next;
    push_rec.point_norm_sq  = pn_next;
    push_rec.center_norm_sq = cn_next;
    push_rec.over_dim       = count_next > 13'(MAX_DIM);
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      diff_sum       <= '0;
      dot_sum        <= '0;
      point_norm_sq  <= '0;
      center_norm_sq <= '0;
      element_count  <= '0;
      diff_sat       <= 1'b0;
      cos_sat        <= 1'b0;
    end else if (en && b_valid) begin
      diff_sum       <= diff_next;
      dot_sum        <= dot_next;
      point_norm_sq  <= pn_next;
      center_norm_sq <= cn_next;
      element_count  <= count_next;
      diff_sat       <= diff_sat_next;
      cos_sat        <= cos_sat_next;
    end
  end
endmodule

// ----- hdl/vde_queue.sv -----
// Two-entry queue of finished vector sums between front and back.
module vde_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  vde_pkg::rec_t push_rec,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output vde_pkg::rec_t head_rec
);
  vde_pkg::rec_t mem [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full      = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign head_rec  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

// ----- hdl/vde_back.sv -----
// Back end: finishes a vector's distance, with square roots and a divide for cosine.
module vde_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  vde_pkg::rec_t q_rec,
  output logic          pop,
  output logic          out_valid,
  output vde_pkg::out_t out_data,
  input  logic          out_stall
);
  typedef enum logic [2:0] {IDLE, SQRT, MUL, DIVINIT, DIV, FIN, HOLD} state_t;

  localparam logic [30:0] ONE = 31'h4000_0000;

  state_t state;
  logic [5:0] cnt;
  logic neg;
  logic [40:0] num;
  logic [63:0] xp, xc, resp, resc, bitv;
  logic [61:0] den;
  logic [63:0] r;
  logic [51:0] q;
  logic [63:0] tp, tc, r2;
  logic gp, gc;
  logic [30:0] qc;

  assign pop = (state == IDLE) && q_valid;
  assign tp  = resp + bitv;
  assign tc  = resc + bitv;
  assign gp  = xp >= tp;
  assign gc  = xc >= tc;
  assign r2  = {r[62:0], 1'b0};
  assign qc  = (q > 52'(ONE)) ? ONE : q[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (q_valid) begin
            neg  <= q_rec.dot_sum[40];
            num  <= q_rec.dot_sum[40] ? unsigned'(-q_rec.dot_sum)
                                      : unsigned'(q_rec.dot_sum);
            xp   <= {2'b0, q_rec.point_norm_sq, 22'b0};
            xc   <= {2'b0, q_rec.center_norm_sq, 22'b0};
            resp <= '0;
            resc <= '0;
            bitv <= 64'h4000_0000_0000_0000;
            cnt  <= '0;
            priority if (q_rec.metric == vde_pkg::METRIC_INVALID) begin
              out_data  <= '{distance: '0, status: vde_pkg::STATUS_BAD};
              out_valid <= 1'b1;
              state     <= HOLD;
            end else if (q_rec.over_dim ||
                         (q_rec.metric == vde_pkg::METRIC_COSINE ? q_rec.cos_sat
                                                                  : q_rec.diff_sat)) begin
              out_data  <= '{distance: vde_pkg::DIST_MAX, status: vde_pkg::STATUS_SAT};
              out_valid <= 1'b1;
              state     <= HOLD;
            end else if (q_rec.metric == vde_pkg::METRIC_COSINE) begin
              if (q_rec.point_norm_sq == '0 || q_rec.center_norm_sq == '0) begin
                out_data  <= '{distance: '0, status: vde_pkg::STATUS_ZERO_NORM};
                out_valid <= 1'b1;
                state     <= HOLD;
              end else begin
                state <= SQRT;
              end
            end else begin
              out_data  <= '{distance: q_rec.diff_sum, status: vde_pkg::STATUS_OK};
              out_valid <= 1'b1;
              state     <= HOLD;
            end
          end
        end
        SQRT: begin
          if (gp) begin
            xp   <= xp - tp;
            resp <= (resp >> 1) + bitv;
          end else begin
            resp <= resp >> 1;
          end
          if (gc) begin
            xc   <= xc - tc;
            resc <= (resc >> 1) + bitv;
          end else begin
            resc <= resc >> 1;
          end
          bitv <= bitv >> 2;
          cnt  <= cnt + 6'd1;
          if (cnt == 6'd31) begin
            state <= MUL;
          end
        end
        MUL: begin
          den   <= 62'(resp[30:0]) * 62'(resc[30:0]);
          state <= DIVINIT;
        end
        DIVINIT: begin
          r   <= 64'(num);
          cnt <= '0;
          if (62'(num) >= den) begin
            q     <= 52'(ONE);
            state <= FIN;
          end else begin
            q     <= '0;
            state <= DIV;
          end
        end
        DIV: begin
          if (r2 >= 64'(den)) begin
            r <= r2 - 64'(den);
            q <= {q[50:0], 1'b1};
          end else begin
            r <= r2;
            q <= {q[50:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd51) begin
            state <= FIN;
          end
        end
        FIN: begin
          out_data.distance <= neg ? 48'(ONE) + 48'(qc) : 48'(ONE) - 48'(qc);
          out_data.status   <= vde_pkg::STATUS_OK;
          out_valid         <= 1'b1;
          state             <= HOLD;
        end
        HOLD: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

// ----- sim/tb_vector_distance_engine.sv -----
// Vector distance engine testbench: directed and random vectors checked by a built-in predictor.
`timescale 1ns / 100ps
module tb_vector_distance_engine;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic in_valid;
  logic in_stall;
  vde_pkg::in_t in_data;
  logic out_valid;
  logic out_stall;
  vde_pkg::out_t out_data;

  vector_distance_engine u_top (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  localparam int MAX_DIM = 128;
  localparam logic [2:0] ADDR_METRIC = 3'd0;

  vde_pkg::in_t request_queue[$];
  vde_pkg::out_t distance_queue[$];
  int error_count;
  int send_idle_pct;
  int recv_idle_pct;

  logic [1:0] cur_metric;
  logic [47:0] acc_diff;
  logic signed [40:0] acc_dot;
  logic [39:0] acc_pnorm;
  logic [39:0] acc_cnorm;
  int acc_count;
  bit diff_clamped;
  bit cos_clamped;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [47:0] cosine_of_sums();
    logic [63:0] rp;
    logic [63:0] rc;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] q;
    logic [64:0] r;
    rp = int_sqrt({24'd0, acc_pnorm} << 22);
    rc = int_sqrt({24'd0, acc_cnorm} << 22);
    den = rp * rc;
    num = acc_dot < 0 ? 64'(-64'(acc_dot)) : 64'(acc_dot);
    q = 0;
    if (den == 0) return vde_pkg::ONE_Q30;
    if (num >= den) begin
      q = 64'(vde_pkg::ONE_Q30);
    end else begin
      r = {1'b0, num};
      for (int i = 0; i < 52; i++) begin
        r <<= 1;
        q <<= 1;
        if (r >= {1'b0, den}) begin
          r -= {1'b0, den};
          q |= 64'd1;
        end
      end
      if (q > 64'(vde_pkg::ONE_Q30)) q = 64'(vde_pkg::ONE_Q30);
    end
    return acc_dot < 0 ? 48'(64'(vde_pkg::ONE_Q30) + q) : 48'(64'(vde_pkg::ONE_Q30) - q);
  endfunction

  function automatic void clear_accumulators();
    acc_diff = 0;
    acc_dot = 0;
    acc_pnorm = 0;
    acc_cnorm = 0;
    acc_count = 0;
    diff_clamped = 0;
    cos_clamped = 0;
  endfunction

  function automatic void predict_distance(input vde_pkg::in_t req);
    longint p;
    longint c;
    longint d;
    longint ad;
    longint dot;
    logic [63:0] s;
    vde_pkg::out_t res;
    p = req.point_value;
    c = req.center_value;
    d = p - c;
    ad = d < 0 ? -d : d;
    if (cur_metric == vde_pkg::METRIC_L1 || cur_metric == vde_pkg::METRIC_L2SQ) begin
      s = 64'(acc_diff) + (cur_metric == vde_pkg::METRIC_L1 ? 64'(ad) : 64'(ad * ad));
      if (s > 64'(vde_pkg::DIST_MAX)) begin
        s = 64'(vde_pkg::DIST_MAX);
        diff_clamped = 1;
      end
      acc_diff = s[47:0];
    end
    dot = longint'(acc_dot) + p * c;
    if (dot > (64'sd1 <<< 40) - 1) begin
      dot = (64'sd1 <<< 40) - 1;
      cos_clamped = 1;
    end else if (dot < -(64'sd1 <<< 40)) begin
      dot = -(64'sd1 <<< 40);
      cos_clamped = 1;
    end
    acc_dot = dot[40:0];
    s = 64'(acc_pnorm) + 64'(p * p);
    if (s > 64'hFF_FFFF_FFFF) begin
      s = 64'hFF_FFFF_FFFF;
      cos_clamped = 1;
    end
    acc_pnorm = s[39:0];
    s = 64'(acc_cnorm) + 64'(c * c);
    if (s > 64'hFF_FFFF_FFFF) begin
      s = 64'hFF_FFFF_FFFF;
      cos_clamped = 1;
    end
    acc_cnorm = s[39:0];
    if (acc_count < 8191) acc_count++;
    if (!req.last_element) return;
    res.distance = 0;
    res.status = vde_pkg::STATUS_OK;
    if (cur_metric == vde_pkg::METRIC_INVALID) begin
      res.status = vde_pkg::STATUS_BAD;
    end else if (acc_count > MAX_DIM ||
                 (cur_metric == vde_pkg::METRIC_COSINE ? cos_clamped : diff_clamped)) begin
      res.distance = vde_pkg::DIST_MAX;
      res.status = vde_pkg::STATUS_SAT;
    end else if (cur_metric == vde_pkg::METRIC_COSINE) begin
      if (acc_pnorm == 0 || acc_cnorm == 0) res.status = vde_pkg::STATUS_ZERO_NORM;
      else res.distance = cosine_of_sums();
    end else begin
      res.distance = acc_diff;
    end
    distance_queue.push_back(res);
    clear_accumulators();
  endfunction

  // Driver: the request at the head of the queue is predicted when accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_distance(in_data);
        void'(request_queue.pop_front());
      end
      if (!(in_valid && in_stall)) begin
        if (request_queue.size() > 0 &&
            $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= request_queue[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    vde_pkg::out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (distance_queue.size() == 0) begin
        report_mismatch("unexpected result", out_data.distance, 48'd0);
      end else begin
        want = distance_queue.pop_front();
        if (out_data.distance !== want.distance)
          report_mismatch("distance", out_data.distance, want.distance);
        if (out_data.status !== want.status)
          report_mismatch("status", 48'(out_data.status), 48'(want.status));
      end
    end
  end

  task automatic write_metric(input logic [1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_METRIC;
    pwdata <= {30'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_metric = value;
  endtask

  task automatic wait_idle();
    while (request_queue.size() != 0 || in_valid || distance_queue.size() != 0)
      @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_sample(input int mode);
    case (mode)
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sd0;
      3: return 16'($urandom_range(8191)) - 16'sd4096;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_vector(input int len, input int mode);
    vde_pkg::in_t req;
    for (int i = 0; i < len; i++) begin
      req.point_value = rand_sample(mode == 5 ? $urandom_range(4) : mode);
      req.center_value = rand_sample(mode == 5 ? $urandom_range(4) : mode);
      req.last_element = (i == len - 1);
      request_queue.push_back(req);
    end
  endtask

  task automatic random_phase(input int items);
    int sent;
    int len;
    sent = 0;
    while (sent < items) begin
      len = $urandom_range(99) < 5 ? $urandom_range(MAX_DIM + 20, MAX_DIM) :
            $urandom_range(12, 1);
      queue_vector(len, $urandom_range(99) < 10 ? $urandom_range(2) : 3 + $urandom_range(2));
      sent += len;
      if ($urandom_range(99) < 5) begin
        wait_idle();
        write_metric(2'($urandom));
      end
    end
    wait_idle();
  endtask

  initial begin
    vde_pkg::in_t req;
    error_count = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    cur_metric = vde_pkg::METRIC_L1;
    clear_accumulators();
    send_idle_pct = 12;
    recv_idle_pct = 72;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (int m = 0; m < 4; m++) begin
      write_metric(2'(m));
      queue_vector(1, 0);
      queue_vector(2, 1);
      queue_vector(1, 2);
      queue_vector(3, 5);
      wait_idle();
    end
    write_metric(vde_pkg::METRIC_L2SQ);
    queue_vector(4, 0);
    wait_idle();
    write_metric(vde_pkg::METRIC_COSINE);
    req.point_value = 16'sh0100;
    req.center_value = -16'sh0100;
    req.last_element = 1'b1;
    request_queue.push_back(req);
    queue_vector(MAX_DIM + 1, 3);
    wait_idle();
    random_phase(460);
    send_idle_pct = 72;
    recv_idle_pct = 12;
    random_phase(460);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(460);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
